FILE: sv/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and reset.
`define HFE_ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same, on the block's clock and reset.
`define HFE_ASSERT(label, prop, msg) \
   `HFE_ASSERT_CLK(label, clock, reset, prop, msg)

`endif

FILE: sv/hfe_pkg.sv
package hfe_pkg;

   localparam int SAMPLE_W          = 16;
   localparam int TAPS_DEFAULT      = 65;
   localparam int COEF_FRAC_DEFAULT = 15;

   // pi and one in Q30
   localparam longint unsigned PI_Q30  = 64'd3373259426;
   localparam longint          ONE_Q30 = 64'sd1073741824;

   // per-cell control: move the neighbor's value in, optionally as zero
   typedef struct packed {
      logic shift;
      logic zero;
   } hfe_cell_ctrl_type;

   // MAC control: clear the sum, take one tap this cycle
   typedef struct packed {
      logic clear;
      logic en;
   } hfe_mac_ctrl_type;

endpackage

FILE: sv/hfe_cell.sv
module hfe_cell
   import hfe_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  hfe_cell_ctrl_type          ctrl,
   input  logic signed [SAMPLE_W-1:0] left_value,
   output logic signed [SAMPLE_W-1:0] value
);

   logic signed [SAMPLE_W-1:0] value_ff;
   logic signed [SAMPLE_W-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      if (ctrl.shift) begin
         value_in = ctrl.zero ? '0 : left_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= '0;
      end else begin
         value_ff <= value_in;
      end
   end

   assign value = value_ff;

endmodule

FILE: sv/hfe_mac.sv
module hfe_mac
   import hfe_pkg::*;
#(
   parameter int TAPS           = TAPS_DEFAULT,
   parameter int COEF_FRAC_BITS = COEF_FRAC_DEFAULT
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  hfe_mac_ctrl_type           ctrl,
   input  logic [$clog2(TAPS)-1:0]    tap,
   input  logic signed [SAMPLE_W-1:0] sample,
   output logic signed [SAMPLE_W-1:0] quadrature
);

   localparam int CW = COEF_FRAC_BITS + 2;
   localparam int PW = CW + SAMPLE_W;
   localparam int AW = PW + $clog2(TAPS);

   localparam logic signed [AW-1:0] Q_MAX  = AW'(32'sd32767);
   localparam logic signed [AW-1:0] Q_MIN  = AW'(-32'sd32768);
   localparam logic signed [AW-1:0] ROUNDER = AW'(1) <<< (COEF_FRAC_BITS - 1);

   logic signed [CW-1:0] coef_rom [TAPS];

   // Hamming-windowed Hilbert taps, worked out at elaboration.
   // Cosine: angle folded into [0, pi/2], ten-term Taylor series in Q30.
   for (genvar g = 0; g < TAPS; g++) begin : g_coef
      localparam int unsigned     D    = TAPS - 1;
      localparam int              MID  = (TAPS - 1) / 2;
      localparam int              K    = g - MID;
      localparam int unsigned     AK   = (K < 0) ? -K : K;
      localparam int unsigned     A    = (g <= D - g) ? g : D - g;
      localparam bit              NEG  = (4 * A > D);
      localparam longint unsigned NUM  = NEG ? D - 2 * A : 2 * A;
      localparam longint unsigned X    = (PI_Q30 * NUM) / D;
      localparam longint unsigned X2   = (X * X) >> 30;
      localparam longint unsigned M1   = ((longint'(ONE_Q30) * X2) >> 30) / 2;
      localparam longint unsigned M2   = ((M1 * X2) >> 30) / 12;
      localparam longint unsigned M3   = ((M2 * X2) >> 30) / 30;
      localparam longint unsigned M4   = ((M3 * X2) >> 30) / 56;
      localparam longint unsigned M5   = ((M4 * X2) >> 30) / 90;
      localparam longint unsigned M6   = ((M5 * X2) >> 30) / 132;
      localparam longint unsigned M7   = ((M6 * X2) >> 30) / 182;
      localparam longint unsigned M8   = ((M7 * X2) >> 30) / 240;
      localparam longint unsigned M9   = ((M8 * X2) >> 30) / 306;
      localparam longint          SUM  = ONE_Q30 - longint'(M1) + longint'(M2)
                                         - longint'(M3) + longint'(M4) - longint'(M5)
                                         + longint'(M6) - longint'(M7) + longint'(M8)
                                         - longint'(M9);
      localparam longint          C    = NEG ? -SUM : SUM;
      localparam longint          W    = (54 * ONE_Q30 - 46 * C) / 100;
      localparam longint unsigned NUMER = longint'(W) << (COEF_FRAC_BITS + 1);
      localparam longint unsigned DEN  = PI_Q30 * ((AK == 0) ? 1 : AK);
      localparam longint unsigned MAG  = (NUMER + DEN / 2) / DEN;
      localparam logic signed [CW-1:0] MAG_S = signed'(CW'(MAG));
      localparam logic signed [CW-1:0] COEF  =
         (AK % 2 == 1) ? ((K < 0) ? -MAG_S : MAG_S) : '0;
      assign coef_rom[g] = COEF;
   end

   logic                 prod_vld_ff;
   logic signed [PW-1:0] prod_ff;
   logic signed [PW-1:0] prod_in;
   logic signed [AW-1:0] acc_ff;
   logic signed [AW-1:0] acc_in;
   logic signed [AW-1:0] rounded;
   logic signed [AW-1:0] scaled;

   assign prod_in = coef_rom[tap] * sample;

   always_comb begin
      acc_in = acc_ff;
      if (ctrl.clear) begin
         acc_in = '0;
      end else if (prod_vld_ff) begin
         acc_in = acc_ff + AW'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= ctrl.en & ~ctrl.clear;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   // round half up, floor shift, saturate to 16 bits
   assign rounded = acc_ff + ROUNDER;
   assign scaled  = rounded >>> COEF_FRAC_BITS;

   always_comb begin
      if (scaled > Q_MAX) begin
         quadrature = Q_MAX[SAMPLE_W-1:0];
      end else if (scaled < Q_MIN) begin
         quadrature = Q_MIN[SAMPLE_W-1:0];
      end else begin
         quadrature = scaled[SAMPLE_W-1:0];
      end
   end

endmodule

FILE: sv/hfe_isqrt.sv
module hfe_isqrt
   import hfe_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic signed [SAMPLE_W-1:0] in_phase,
   input  logic signed [SAMPLE_W-1:0] quadrature,
   output logic                       done,
   output logic [SAMPLE_W-1:0]        root
);

   localparam int RW = 2 * SAMPLE_W;        // radicand
   localparam int MW = SAMPLE_W + 2;        // remainder
   localparam int CNT_W = $clog2(SAMPLE_W);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SQ_I,
      S_SQ_Q,
      S_SUM,
      S_ITER
   } state_type;

   state_type                  state_ff;
   logic                       done_ff;
   logic [CNT_W-1:0]           cnt_ff;
   logic signed [SAMPLE_W-1:0] ip_ff;
   logic signed [SAMPLE_W-1:0] q_ff;
   logic [RW-1:0]              sq_a_ff;
   logic [RW-1:0]              sq_b_ff;
   logic [RW-1:0]              rad_ff;
   logic [MW-1:0]              rem_ff;
   logic [SAMPLE_W-1:0]        root_ff;

   logic signed [SAMPLE_W-1:0] sq_op;
   logic signed [RW-1:0]       sq_prod;
   logic [MW+1:0]              rem_in;
   logic [MW+1:0]              trial;
   logic                       fits;

   // one shared squarer
   assign sq_op   = (state_ff == S_SQ_I) ? ip_ff : q_ff;
   assign sq_prod = sq_op * sq_op;

   // one result bit per cycle
   assign rem_in = {rem_ff, rad_ff[RW-1 -: 2]};
   assign trial  = {2'b00, root_ff, 2'b01};
   assign fits   = (rem_in >= trial);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
      end else begin
         // pulse after the last result bit
         done_ff <= (state_ff == S_ITER) && (cnt_ff == '0);
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  ip_ff    <= in_phase;
                  q_ff     <= quadrature;
                  state_ff <= S_SQ_I;
               end
            end
            S_SQ_I: begin
               sq_a_ff  <= sq_prod;
               state_ff <= S_SQ_Q;
            end
            S_SQ_Q: begin
               sq_b_ff  <= sq_prod;
               state_ff <= S_SUM;
            end
            S_SUM: begin
               rad_ff   <= sq_a_ff + sq_b_ff;
               rem_ff   <= '0;
               root_ff  <= '0;
               cnt_ff   <= CNT_W'(SAMPLE_W - 1);
               state_ff <= S_ITER;
            end
            S_ITER: begin
               rad_ff <= {rad_ff[RW-3:0], 2'b00};
               if (fits) begin
                  rem_ff  <= MW'(rem_in - trial);
                  root_ff <= {root_ff[SAMPLE_W-2:0], 1'b1};
               end else begin
                  rem_ff  <= rem_in[MW-1:0];
                  root_ff <= {root_ff[SAMPLE_W-2:0], 1'b0};
               end
               if (cnt_ff == '0) begin
                  state_ff <= S_IDLE;
               end else begin
                  cnt_ff <= cnt_ff - 1'b1;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

FILE: sv/hilbert_fir_envelope.sv
// Channel | Dir | Beat accepted when     | Content
// --------+-----+------------------------+-----------------------------------------------
// req     | in  | req_tvalid & req_tready| tdata[15:0] sample (Q1.15), tuser first_sample
// rsp     | out | rsp_tvalid & rsp_tready| tdata[15:0] envelope, [31:16] quadrature,
//         |     |                        | [47:32] in_phase
//
// One beat at a time: a new req beat is not taken while one is in flight.
// The history rotates once around the cell ring, one tap per cycle through the MAC,
// then the bit-serial square root squares I and Q, sums them and finds the root bit by bit.
// Reset clears the history cells, the sequencer and rsp_tvalid; no clearing pass.
// A stalled rsp holds in the output register; req is taken again as soon as the
// sequencer is back in idle, and a finished result waits only for that register.
module hilbert_fir_envelope
   import hfe_pkg::*;
#(
   parameter int TAPS           = TAPS_DEFAULT,
   parameter int COEF_FRAC_BITS = COEF_FRAC_DEFAULT
)
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] sample
   input  logic        req_tuser,   // [0] first_sample

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata    // [15:0] envelope, [31:16] quadrature, [47:32] in_phase
);

   localparam int TAP_W = $clog2(TAPS);
   localparam int MID   = (TAPS - 1) / 2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_DRAIN,
      ST_START,
      ST_ROOT,
      ST_HOLD
   } state_type;

   state_type                  state_ff;
   logic [TAP_W-1:0]           tap_ff;
   logic                       rsp_valid_ff;
   logic [SAMPLE_W-1:0]        env_out_ff;
   logic signed [SAMPLE_W-1:0] q_out_ff;
   logic signed [SAMPLE_W-1:0] ip_out_ff;
   logic signed [SAMPLE_W-1:0] q_ff;
   logic signed [SAMPLE_W-1:0] ip_ff;

   logic                       req_beat;
   logic                       rotate;
   logic                       out_free;
   logic signed [SAMPLE_W-1:0] sample;
   logic signed [SAMPLE_W-1:0] cell_value [TAPS];
   logic signed [SAMPLE_W-1:0] mac_q;
   hfe_mac_ctrl_type           mac_ctrl;
   logic                       root_start;
   logic                       root_done;
   logic [SAMPLE_W-1:0]        root;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_beat   = req_tvalid & req_tready;
   assign rotate     = (state_ff == ST_MAC);
   assign sample     = signed'(req_tdata);
   assign out_free   = ~rsp_valid_ff | rsp_tready;

   // History ring: cell 0 newest. A req beat shifts the sample in (a first_sample
   // zeroes the rest); in ST_MAC the ring turns once so the last cell walks
   // through every tap, oldest first, and ends where it started.
   for (genvar g = 0; g < TAPS; g++) begin : g_cell
      hfe_cell_ctrl_type          cell_ctrl;
      logic signed [SAMPLE_W-1:0] left_value;

      if (g == 0) begin : g_head
         assign left_value = req_beat ? sample : cell_value[TAPS-1];
         assign cell_ctrl  = '{shift: req_beat | rotate, zero: 1'b0};
      end else begin : g_body
         assign left_value = cell_value[g-1];
         assign cell_ctrl  = '{shift: req_beat | rotate, zero: req_beat & req_tuser};
      end

      hfe_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (cell_ctrl),
         .left_value (left_value),
         .value      (cell_value[g])
      );
   end

   assign mac_ctrl = '{clear: req_beat, en: rotate};

   hfe_mac #(
      .TAPS           (TAPS),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_mac (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (mac_ctrl),
      .tap        (tap_ff),
      .sample     (cell_value[TAPS-1]),
      .quadrature (mac_q)
   );

   assign root_start = (state_ff == ST_START);

   hfe_isqrt u_isqrt (
      .clock      (clock),
      .reset      (reset),
      .start      (root_start),
      .in_phase   (cell_value[MID]),
      .quadrature (mac_q),
      .done       (root_done),
      .root       (root)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // a new result loads as the old beat leaves, else a taken beat clears valid
         if ((state_ff == ST_HOLD) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_beat) begin
                  tap_ff   <= TAP_W'(TAPS - 1);
                  state_ff <= ST_MAC;
               end
            end
            ST_MAC: begin
               if (tap_ff == '0) begin
                  state_ff <= ST_DRAIN;
               end else begin
                  tap_ff <= tap_ff - 1'b1;
               end
            end
            ST_DRAIN: begin
               // last product lands in the sum this cycle
               state_ff <= ST_START;
            end
            ST_START: begin
               q_ff     <= mac_q;
               ip_ff    <= cell_value[MID];
               state_ff <= ST_ROOT;
            end
            ST_ROOT: begin
               if (root_done) begin
                  state_ff <= ST_HOLD;
               end
            end
            ST_HOLD: begin
               if (out_free) begin
                  env_out_ff <= root;
                  q_out_ff   <= q_ff;
                  ip_out_ff  <= ip_ff;
                  state_ff   <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {ip_out_ff, q_out_ff, env_out_ff};

endmodule

FILE: sv/hfe_checker.sv
`include "assert_macros.svh"

module hfe_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [15:0] req_tdata,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata
);

   logic signed [33:0] ip_x;
   logic signed [33:0] q_x;
   logic [33:0]        mag2;
   logic [33:0]        env_x;
   logic [33:0]        env_p1;
   logic               env_ok;
   logic               req_known;

   assign ip_x   = 34'(signed'(rsp_tdata[47:32]));
   assign q_x    = 34'(signed'(rsp_tdata[31:16]));
   assign mag2   = unsigned'(ip_x * ip_x + q_x * q_x);
   assign env_x  = {18'b0, rsp_tdata[15:0]};
   assign env_p1 = env_x + 34'd1;
   // envelope is the floored root of I*I + Q*Q
   assign env_ok = (env_x * env_x <= mag2) && (env_p1 * env_p1 > mag2);

   // payload seen only for its handshake; keeps every port in use
   assign req_known = ^{req_tdata, req_tuser} !== 1'bx;

   `HFE_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "rsp beat dropped while stalled")
   `HFE_ASSERT(a_rsp_stable, rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata), "rsp data changed while stalled")
   `HFE_ASSERT(a_one_in_flight, req_tvalid && req_tready && req_known |=> !req_tready, "req taken while busy")
   `HFE_ASSERT_CLK(a_env_root, clock, reset, rsp_tvalid |-> env_ok, "envelope is not the floored root")

endmodule

bind hilbert_fir_envelope hfe_checker u_hfe_checker (.*);
